### hw/rtl/bb3_pkg.sv
// Package for the 3x3 box blur block: state encoding, register indexes,
// and the reciprocal table used to divide a channel sum by the neighbor count.
// No dependencies.
package bb3_pkg;

  // Configuration register indexes.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd480;

  // Fraction bits of the reciprocal multiply.
  localparam int RECIP_SHIFT = 20;

  // Sequencer states: take a request, sum the window, divide.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV
  } bb3_state_t;

  // Returns ceil(2^RECIP_SHIFT / (2*n)), which makes the product with
  // (2*sum + n) floor exactly for every count that a window can have.
  function automatic logic [19:0] recip(input logic [3:0] n);
    logic [19:0] r;
    case (n)
      4'd1:    r = 20'd524288;
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd6:    r = 20'd87382;
      4'd9:    r = 20'd58255;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/bb3_if.sv
// Stream interfaces of the box blur block: pixel input and blurred output.
// Each carries valid, ready and its payload. No dependencies.
interface bb3_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, action, red, green, blue, input ready);
  modport sink   (input valid, action, red, green, blue, output ready);
endinterface

interface bb3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_done;

  modport source (output valid, out_red, out_green, out_blue, frame_done, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_done, output ready);
endinterface

### hw/rtl/box_blur_3x3_edge_average.sv
// 3x3 box blur of an RGB raster stream. A request that yields a result goes through
// a read of the line memory, the window sum with the memory written back, and the
// reciprocal multiply that forms the rounded mean. The multiply step repeats while
// the previous result is still held at the output. A request that yields no result
// ends after the sum, and a dropped flush goes no further than the handshake.
// A finished result waits in an output register, so the next request is taken while
// it is pending. The output for a pixel appears once the pixel one row and one column
// beyond it is in; after the last pixel, frame_width + 1 flush requests drain the
// frame and the final result carries frame_done. Flush requests sent before the
// frame is complete are dropped. Frame size is latched at the first request of a
// frame; zero is taken as one and widths above MAX_WIDTH are clipped.
// Depends on bb3_pkg and bb3_if.
module box_blur_3x3_edge_average #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  bb3_in_if.sink           in,
  bb3_out_if.source        out,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  // Configuration registers.
  logic [10:0] frame_width;
  logic [15:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::FRAME_WIDTH_RESET;
      frame_height <= bb3_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bb3_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        bb3_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bb3_pkg::bb3_state_t state, state_next;

  logic          frame_start;
  logic [CW-1:0] cur_w;
  logic [15:0]   cur_h;
  logic [CW-1:0] in_column;
  logic [16:0]   in_row;
  logic [CW-1:0] out_column;
  logic [15:0]   out_row;

  logic [AW-1:0] addr_q;
  logic [23:0]   pix_q;
  logic          emit_q;
  logic          last_q;
  logic [11:0]   sum_r, sum_g, sum_b;
  logic [3:0]    cnt_q;

  logic [23:0]   win [2][3];
  logic [47:0]   mem [MAX_WIDTH];
  logic [47:0]   rd_data;

  logic          accept;
  logic          out_free;
  logic [CW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [CW-1:0] w_sat;
  logic [15:0]   h_sat;
  logic          ignore;

  assign accept   = in.valid && in.ready;
  assign out_free = !out.valid || out.ready;
  assign in.ready = (state == bb3_pkg::ST_IDLE);

  // Frame size as it applies to this request.
  always_comb begin
    if (frame_width == 11'd0) begin
      w_sat = CW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_sat = CW'(MAX_WIDTH);
    end else begin
      w_sat = CW'(frame_width);
    end
    h_sat = (frame_height == 16'd0) ? 16'd1 : frame_height;
    w_eff = frame_start ? w_sat : cur_w;
    h_eff = frame_start ? h_sat : cur_h;
    ignore = in.action && (in_row < {1'b0, h_eff});
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      bb3_pkg::ST_IDLE: if (accept && !ignore) state_next = bb3_pkg::ST_SUM;
      bb3_pkg::ST_SUM:  state_next = emit_q ? bb3_pkg::ST_DIV : bb3_pkg::ST_IDLE;
      bb3_pkg::ST_DIV:  if (out_free) state_next = bb3_pkg::ST_IDLE;
      default:          state_next = bb3_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bb3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Line memory: each entry holds the two previous rows of one column.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[in_column[AW-1:0]];
    end
    if (state == bb3_pkg::ST_SUM) begin
      mem[addr_q] <= {rd_data[23:0], pix_q};
    end
  end

  // Window sum with masking of neighbors outside the frame.
  logic [23:0] col_new [3];
  logic        row_ok [3];
  logic        col_ok [3];
  logic [11:0] s_r, s_g, s_b;
  logic [1:0]  n_rows, n_cols;
  logic [3:0]  n_all;
  logic [23:0] px;

  always_comb begin
    col_new[0] = rd_data[47:24];
    col_new[1] = rd_data[23:0];
    col_new[2] = pix_q;
    row_ok[0] = (out_row != 16'd0);
    row_ok[1] = 1'b1;
    row_ok[2] = (17'(out_row) + 17'd1 < 17'(cur_h));
    col_ok[0] = (out_column != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = ((CW+1)'(out_column) + (CW+1)'(1) < (CW+1)'(cur_w));
    s_r = '0;
    s_g = '0;
    s_b = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        px = (c == 2) ? col_new[r] : win[c[0]][r];
        if (row_ok[r] && col_ok[c]) begin
          s_r = s_r + 12'(px[23:16]);
          s_g = s_g + 12'(px[15:8]);
          s_b = s_b + 12'(px[7:0]);
        end
      end
    end
    n_rows = 2'd1 + 2'(row_ok[0]) + 2'(row_ok[2]);
    n_cols = 2'd1 + 2'(col_ok[0]) + 2'(col_ok[2]);
    n_all  = 4'(n_rows) * 4'(n_cols);
  end

  // Reciprocal multiply for the rounded mean.
  logic [19:0] rcp;
  logic [32:0] q_r, q_g, q_b;

  always_comb begin
    rcp = bb3_pkg::recip(cnt_q);
    q_r = ({20'd0, sum_r, 1'b0} + 33'(cnt_q)) * 33'(rcp);
    q_g = ({20'd0, sum_g, 1'b0} + 33'(cnt_q)) * 33'(rcp);
    q_b = ({20'd0, sum_b, 1'b0} + 33'(cnt_q)) * 33'(rcp);
  end

  // Counters, window and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_start <= 1'b1;
      cur_w       <= CW'(1);
      cur_h       <= 16'd1;
      in_column   <= '0;
      in_row      <= '0;
      out_column  <= '0;
      out_row     <= '0;
      emit_q      <= 1'b0;
      out.valid   <= 1'b0;
    end else begin
      // A held result leaves at its handshake; the divide stage loads the next one.
      if (out.valid && out.ready && state != bb3_pkg::ST_DIV) begin
        out.valid <= 1'b0;
      end
      case (state)
        bb3_pkg::ST_IDLE: begin
          if (accept && !ignore) begin
            frame_start <= 1'b0;
            cur_w       <= w_eff;
            cur_h       <= h_eff;
            addr_q      <= in_column[AW-1:0];
            pix_q       <= {in.red, in.green, in.blue};
            emit_q      <= (in_row > 17'd1) || (in_row == 17'd1 && in_column != '0);
            if (in_column + CW'(1) >= w_eff) begin
              in_column <= '0;
              in_row    <= in_row + 17'd1;
            end else begin
              in_column <= in_column + CW'(1);
            end
          end
        end
        bb3_pkg::ST_SUM: begin
          win[0] <= win[1];
          win[1] <= col_new;
          if (emit_q) begin
            sum_r  <= s_r;
            sum_g  <= s_g;
            sum_b  <= s_b;
            cnt_q  <= n_all;
            last_q <= (out_row == cur_h - 16'd1) && (out_column == cur_w - CW'(1));
            if (out_row == cur_h - 16'd1 && out_column == cur_w - CW'(1)) begin
              frame_start <= 1'b1;
              in_column   <= '0;
              in_row      <= '0;
              out_column  <= '0;
              out_row     <= '0;
            end else if (out_column + CW'(1) >= cur_w) begin
              out_column <= '0;
              out_row    <= out_row + 16'd1;
            end else begin
              out_column <= out_column + CW'(1);
            end
          end
        end
        bb3_pkg::ST_DIV: begin
          if (out_free) begin
            out.valid      <= 1'b1;
            out.out_red    <= q_r[bb3_pkg::RECIP_SHIFT +: 8];
            out.out_green  <= q_g[bb3_pkg::RECIP_SHIFT +: 8];
            out.out_blue   <= q_b[bb3_pkg::RECIP_SHIFT +: 8];
            out.frame_done <= last_q;
          end
        end
        default: ;
      endcase
    end
  end

  // With a result to emit, the sum stage always hands over to the divide.
  assert property (@(posedge clk) disable iff (rst)
    state == bb3_pkg::ST_SUM && emit_q |=> state == bb3_pkg::ST_DIV)
    else $error("sum stage did not move to divide");

  // Only a count that a clipped 3x3 window can have reaches the divider.
  assert property (@(posedge clk) disable iff (rst)
    state == bb3_pkg::ST_DIV |-> (cnt_q == 4'd1 || cnt_q == 4'd2 || cnt_q == 4'd3 ||
                                  cnt_q == 4'd4 || cnt_q == 4'd6 || cnt_q == 4'd9))
    else $error("neighbor count out of range");

  // The input column stays inside the latched frame width.
  assert property (@(posedge clk) disable iff (rst)
    !frame_start |-> in_column < cur_w)
    else $error("input column beyond frame width");

  // A result is never dropped: the divide waits while the output is held.
  assert property (@(posedge clk) disable iff (rst)
    state == bb3_pkg::ST_DIV && out.valid && !out.ready |=> state == bb3_pkg::ST_DIV)
    else $error("divide stage left while output stalled");

endmodule

### verif/testbench.sv
// Testbench for the 3x3 box blur with edge averaging: frames of RGB pixels
// are streamed in, and every blurred pixel is checked against a predictor.
// Depends on bb3_pkg, bb3_if and box_blur_3x3_edge_average.
`timescale 1ns / 1ps

module testbench;

  localparam int RING_DEPTH = 2 * 1024 + 4;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_done;
  } blur_pixel_t;

  // Predicts the blurred stream and holds the pixels still owed by the block.
  class blur_scoreboard;
    logic [23:0]  ring[RING_DEPTH];
    logic [10:0]  width_reg = bb3_pkg::FRAME_WIDTH_RESET;
    logic [15:0]  height_reg = bb3_pkg::FRAME_HEIGHT_RESET;
    int unsigned  tick, frame_w = 1, frame_h = 1, col, row;
    blur_pixel_t  pending[$];
    int           errors;
    int           results_seen;

    function void write_reg(logic idx, logic [15:0] value);
      if (idx == bb3_pkg::REG_FRAME_WIDTH) width_reg = value[10:0];
      else height_reg = value;
    endfunction

    function void note_request(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned total, step, sr, sg, sb, n, pos;
      int rr, cc;
      blur_pixel_t px;
      if (tick == 0) begin
        frame_w = (width_reg == 0) ? 1 : ((width_reg > 1024) ? 1024 : width_reg);
        frame_h = (height_reg == 0) ? 1 : height_reg;
      end
      total = frame_w * frame_h;
      if (tick < total) begin
        // A flush tick before the frame is complete is dropped.
        if (act) return;
        ring[tick % RING_DEPTH] = {r, g, b};
      end
      step = tick;
      tick++;
      if (step < frame_w + 1) return;
      sr = 0; sg = 0; sb = 0; n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = int'(row) + dr;
          cc = int'(col) + dc;
          if (rr >= 0 && cc >= 0 && rr < int'(frame_h) && cc < int'(frame_w)) begin
            pos = (rr * frame_w + cc) % RING_DEPTH;
            sr += ring[pos][23:16];
            sg += ring[pos][15:8];
            sb += ring[pos][7:0];
            n++;
          end
        end
      end
      px.red = 8'((2 * sr + n) / (2 * n));
      px.green = 8'((2 * sg + n) / (2 * n));
      px.blue = 8'((2 * sb + n) / (2 * n));
      px.frame_done = ((step - frame_w - 1) == total - 1);
      pending.push_back(px);
      if (px.frame_done) begin
        tick = 0; col = 0; row = 0;
      end else begin
        col++;
        if (col >= frame_w) begin
          col = 0;
          row++;
        end
      end
    endfunction

    function void check_result(blur_pixel_t got);
      blur_pixel_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", got.red, got.green, got.blue);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red) begin
        $error("out_red: expected %0d, actual %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("out_green: expected %0d, actual %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("out_blue: expected %0d, actual %0d", want.blue, got.blue);
        errors++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %0d, actual %0d", want.frame_done, got.frame_done);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = bb3_pkg::REG_FRAME_WIDTH;
  logic [15:0] cfg_data = '0;
  bit          idling_on = 1'b1;
  bit          hold_request = 1'b0;
  int          cycles;
  int          requests_sent;
  int          frames_run;

  bb3_in_if  pix_in();
  bb3_out_if pix_out();

  blur_scoreboard blur_sb = new();

  box_blur_3x3_edge_average dut (
    .clk(clk), .rst(rst), .in(pix_in), .out(pix_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    pix_in.valid = 1'b0;
    pix_in.action = 1'b0;
    pix_in.red = '0;
    pix_in.green = '0;
    pix_in.blue = '0;
    pix_out.ready = 1'b1;
  end

  // Sample both handshakes at the rising edge and watch the cycle budget.
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_in.valid && pix_in.ready)
        blur_sb.note_request(pix_in.action, pix_in.red, pix_in.green, pix_in.blue);
      if (pix_out.valid && pix_out.ready)
        blur_sb.check_result({pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                              pix_out.frame_done});
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        pix_out.ready = 1'b0;
        repeat (400) @(negedge clk);
        pix_out.ready = 1'b1;
        hold_request = 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        pix_out.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        pix_out.ready = 1'b1;
      end
    end
  end

  task automatic write_cfg(logic idx, logic [15:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    blur_sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offers one request, called at a falling edge; returns at the falling edge after it is taken.
  task automatic send_request(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      pix_in.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    pix_in.valid = 1'b1;
    pix_in.action = act;
    pix_in.red = r;
    pix_in.green = g;
    pix_in.blue = b;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  // Runs one frame: pixels, with stray early flushes in the random frames, then the drain.
  task automatic run_frame(logic [10:0] w_reg, logic [15:0] h_reg, bit extremes, bit long_hold);
    int unsigned w, h, total;
    logic [7:0] v;
    write_cfg(bb3_pkg::REG_FRAME_WIDTH, {5'd0, w_reg});
    write_cfg(bb3_pkg::REG_FRAME_HEIGHT, h_reg);
    w = (w_reg == 0) ? 1 : ((w_reg > 1024) ? 1024 : w_reg);
    h = (h_reg == 0) ? 1 : h_reg;
    total = w * h;
    for (int unsigned i = 0; i < total; i++) begin
      if (long_hold && i == w + 5) hold_request = 1'b1;
      if (!extremes && $urandom_range(0, 15) == 0)
        send_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
      if (extremes) begin
        v = (i % 2 == 0) ? 8'hFF : 8'h00;
        send_request(1'b0, v, ~v, v);
      end else begin
        send_request(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    // Pixels sent while draining count as flush ticks.
    for (int unsigned i = 0; i <= w; i++)
      send_request(1'($urandom_range(0, 2) != 0), 8'($urandom), 8'($urandom), 8'($urandom));
    pix_in.valid = 1'b0;
    // Hold the sender until the frame has fully drained.
    while (blur_sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    frames_run++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed frames: single pixel, zero size, corners and edges, extremes.
    run_frame(11'd1, 16'd1, 1'b1, 1'b0);
    run_frame(11'd0, 16'd0, 1'b1, 1'b0);
    run_frame(11'd3, 16'd3, 1'b1, 1'b0);
    run_frame(11'd2, 16'd2, 1'b1, 1'b0);

    // A single column, and a wider frame that takes a long output stall.
    run_frame(11'd1, 16'd5, 1'b0, 1'b0);
    run_frame(11'd64, 16'd6, 1'b0, 1'b1);

    // Random small frames; the last stretch runs with no idling.
    while (requests_sent < 1750) begin
      if (requests_sent > 1400) idling_on = 1'b0;
      run_frame(11'($urandom_range(1, 9)), 16'($urandom_range(1, 7)), 1'b0, 1'b0);
    end

    repeat (20) @(negedge clk);
    $display("Ran %0d frames with %0d requests, %0d blurred pixels checked.",
             frames_run, requests_sent, blur_sb.results_seen);
    $display("Sizes ranged from one pixel to a 64 pixel wide frame held off at the output.");
    if (blur_sb.errors == 0 && blur_sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (blur_sb.pending.size() != 0)
        $error("%0d expected pixels never arrived", blur_sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
